// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker module of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SCFL_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scfl assertion failed");

// Next-cycle implication, disabled while reset is high.
`define SCFL_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scfl assertion failed");

`endif

// ----- hdl/scfl_pkg.sv -----
// Package with the types, codes and constants of the size-class allocator.
`timescale 1ns / 1ps
package scfl_pkg;

   localparam int CMD_W   = 2;
   localparam int SIZE_W  = 16;
   localparam int ADDR_W  = 32;
   localparam int CNT_W   = 32;
   localparam int CLASS_W = 3;
   localparam int ROUND_W = 13;
   localparam int STAT_W  = 3;

   localparam int MIN_CLASS_BYTES = 32;
   localparam int MAX_CLASSES     = 8;

   localparam int DEF_LIST_DEPTH   = 256;
   localparam int DEF_HEADER_BYTES = 16;
   localparam int DEF_NUM_CLASSES  = 8;

   localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_NOTE  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_STATS = 2'd3;

   localparam logic [STAT_W-1:0] ST_REUSED    = 3'd0;
   localparam logic [STAT_W-1:0] ST_FRESH     = 3'd1;
   localparam logic [STAT_W-1:0] ST_LARGE     = 3'd2;
   localparam logic [STAT_W-1:0] ST_FREED     = 3'd3;
   localparam logic [STAT_W-1:0] ST_FREE_PASS = 3'd4;
   localparam logic [STAT_W-1:0] ST_BAD_SIZE  = 3'd5;
   localparam logic [STAT_W-1:0] ST_LIST_FULL = 3'd6;
   localparam logic [STAT_W-1:0] ST_STATS     = 3'd7;

   typedef struct packed {
      logic               alloc_hit;
      logic [CLASS_W-1:0] alloc_class;
      logic               free_hit;
      logic [CLASS_W-1:0] free_class;
   } class_dec_type;

   // Block size in bytes of a class.
   function automatic logic [ROUND_W-1:0] class_bytes(input logic [CLASS_W-1:0] c);
      logic [ROUND_W-1:0] base;
      base = ROUND_W'(MIN_CLASS_BYTES);
      return base << c;
   endfunction

endpackage

// ----- hdl/scfl_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
module scfl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/scfl_class_dec.sv -----
// Size-to-class decoder for alloc requests and free headers.
`timescale 1ns / 1ps
module scfl_class_dec import scfl_pkg::*; #(
   parameter int NUM_CLASSES  = DEF_NUM_CLASSES,
   parameter int HEADER_BYTES = DEF_HEADER_BYTES
) (
   input  logic [SIZE_W-1:0] alloc_bytes,
   input  logic [SIZE_W-1:0] header_block_size,
   output class_dec_type     dec
);

   logic [SIZE_W:0] total;

   assign total = {1'b0, alloc_bytes} + (SIZE_W + 1)'(HEADER_BYTES);

   // Walk from the largest class down so the smallest match wins.
   always_comb begin
      dec = '0;
      for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
         if (total <= (SIZE_W + 1)'(class_bytes(CLASS_W'(c)))) begin
            dec.alloc_hit   = 1'b1;
            dec.alloc_class = CLASS_W'(c);
         end
         if (header_block_size == SIZE_W'(class_bytes(CLASS_W'(c)))) begin
            dec.free_hit   = 1'b1;
            dec.free_class = CLASS_W'(c);
         end
      end
   end

endmodule

// ----- hdl/size_class_free_list_allocator.sv -----
// Top level of the size-class free-list allocator.
`timescale 1ns / 1ps
// Size-class allocator bookkeeping. Commands arrive as beats on the req_
// ports and are taken at every rising edge where start is high; busy is
// held low, so one command can be issued in every cycle. Each command except
// note_fresh returns exactly one result beat, shown on the rsp_ ports for
// one cycle with rsp_valid high once it has passed the input and result
// registers. The receiver cannot stall, so results must be captured when
// rsp_valid is seen. Behind the input register the command is decoded,
// the per-class counters and stack fill levels are updated, and the stack
// memory pop or push is started; the result register presents its contents
// together with the registered memory read data. Free lists live in one RAM
// of NUM_CLASSES * LIST_DEPTH addresses, each class owning a slice of
// LIST_DEPTH entries, and need no clearing after reset because only pushed
// entries are ever popped. A free onto a full stack reports list_full and
// keeps nothing. Allocations over 4096 bytes after the header is added pass
// through and add their size to the large_bytes tally.
module size_class_free_list_allocator import scfl_pkg::*; #(
   parameter int LIST_DEPTH   = DEF_LIST_DEPTH,
   parameter int HEADER_BYTES = DEF_HEADER_BYTES,
   parameter int NUM_CLASSES  = DEF_NUM_CLASSES
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [CMD_W-1:0]   req_command,
   input  logic [SIZE_W-1:0]  req_request_size,
   input  logic [ADDR_W-1:0]  req_user_address,
   input  logic [SIZE_W-1:0]  req_header_block_size,
   input  logic               req_header_valid,
   input  logic [CLASS_W-1:0] req_class_select,
   output logic               rsp_valid,
   output logic [STAT_W-1:0]  rsp_status,
   output logic [CLASS_W-1:0] rsp_class_index,
   output logic [ROUND_W-1:0] rsp_rounded_size,
   output logic [ADDR_W-1:0]  rsp_block_address,
   output logic [CNT_W-1:0]   rsp_live_count,
   output logic [CNT_W-1:0]   rsp_free_count,
   output logic [CNT_W-1:0]   rsp_alloc_total,
   output logic [CNT_W-1:0]   rsp_release_total,
   output logic [CNT_W-1:0]   rsp_large_bytes
);

   localparam int FILL_W    = $clog2(LIST_DEPTH + 1);
   localparam int IDX_W     = $clog2(LIST_DEPTH);
   localparam int MEM_DEPTH = NUM_CLASSES * LIST_DEPTH;
   localparam int MEM_AW    = $clog2(MEM_DEPTH);
   localparam int CIDX_W    = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

   // Input register stage.
   logic               in_valid_ff;
   logic [CMD_W-1:0]   cmd_ff;
   logic [SIZE_W-1:0]  req_size_ff;
   logic [ADDR_W-1:0]  addr_ff;
   logic [SIZE_W-1:0]  hsize_ff;
   logic               hvalid_ff;
   logic [CLASS_W-1:0] sel_ff;

   // Per-class bookkeeping, the large-allocation tally and tracked range.
   logic [FILL_W-1:0] fill_ff    [NUM_CLASSES];
   logic [CNT_W-1:0]  live_ff    [NUM_CLASSES];
   logic [CNT_W-1:0]  alloc_ff   [NUM_CLASSES];
   logic [CNT_W-1:0]  release_ff [NUM_CLASSES];
   logic [CNT_W-1:0]  large_ff;
   logic [ADDR_W-1:0] range_low_ff;
   logic [ADDR_W-1:0] range_high_ff;

   // Result register stage.
   logic               rsp_valid_ff;
   logic [STAT_W-1:0]  status_ff;
   logic [CLASS_W-1:0] class_ff;
   logic [ROUND_W-1:0] rounded_ff;
   logic               reuse_ff;
   logic [CNT_W-1:0]   live_out_ff;
   logic [CNT_W-1:0]   free_out_ff;
   logic [CNT_W-1:0]   alloc_out_ff;
   logic [CNT_W-1:0]   release_out_ff;
   logic [CNT_W-1:0]   large_out_ff;

   // Next values.
   logic               rsp_valid_in;
   logic [STAT_W-1:0]  status_in;
   logic [CLASS_W-1:0] class_in;
   logic [ROUND_W-1:0] rounded_in;
   logic [CNT_W-1:0]   live_out_in;
   logic [CNT_W-1:0]   free_out_in;
   logic [CNT_W-1:0]   alloc_out_in;
   logic [CNT_W-1:0]   release_out_in;
   logic [FILL_W-1:0]  fill_in;
   logic [CNT_W-1:0]   live_in;
   logic [CNT_W-1:0]   alloc_in;
   logic [CNT_W-1:0]   release_in;
   logic [CNT_W-1:0]   large_in;
   logic [ADDR_W-1:0]  range_low_in;
   logic [ADDR_W-1:0]  range_high_in;

   class_dec_type      dec;
   logic [CLASS_W-1:0] cur_class;
   logic [CIDX_W-1:0]  cur_idx;
   logic [FILL_W-1:0]  cur_fill;
   logic [FILL_W-1:0]  pop_fill;
   logic               sel_ok;
   logic               addr_ok;
   logic               stack_full;
   logic               do_pop;
   logic               do_push;
   logic               do_alloc;
   logic               do_large;
   logic               do_note;
   logic               report_class;
   logic [ADDR_W-1:0]  hdr_addr;
   logic [MEM_AW-1:0]  mem_base;
   logic [MEM_AW-1:0]  mem_wr_addr;
   logic [MEM_AW-1:0]  mem_rd_addr;
   logic [ADDR_W-1:0]  mem_rd_data;

   // The block never holds a command off.
   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start && !busy;
      end
      if (start && !busy) begin
         cmd_ff      <= req_command;
         req_size_ff <= req_request_size;
         addr_ff     <= req_user_address;
         hsize_ff    <= req_header_block_size;
         hvalid_ff   <= req_header_valid;
         sel_ff      <= req_class_select;
      end
   end

   scfl_class_dec #(
      .NUM_CLASSES  (NUM_CLASSES),
      .HEADER_BYTES (HEADER_BYTES)
   ) u_class_dec (
      .alloc_bytes       (req_size_ff),
      .header_block_size (hsize_ff),
      .dec               (dec)
   );

   // Pick the one class that this command touches.
   always_comb begin
      case (cmd_ff)
         CMD_ALLOC: cur_class = dec.alloc_class;
         CMD_FREE:  cur_class = dec.free_class;
         default:   cur_class = sel_ff;
      endcase
   end

   assign cur_idx    = cur_class[CIDX_W-1:0];
   assign cur_fill   = fill_ff[cur_idx];
   assign pop_fill   = cur_fill - FILL_W'(1);
   assign sel_ok     = {1'b0, sel_ff} < (CLASS_W + 1)'(NUM_CLASSES);
   assign addr_ok    = (addr_ff >= range_low_ff) && (addr_ff <= range_high_ff) && hvalid_ff;
   assign stack_full = cur_fill == FILL_W'(LIST_DEPTH);

   assign do_alloc = in_valid_ff && (cmd_ff == CMD_ALLOC) && dec.alloc_hit;
   assign do_pop   = do_alloc && (cur_fill != '0);
   assign do_large = in_valid_ff && (cmd_ff == CMD_ALLOC) && !dec.alloc_hit;
   assign do_push  = in_valid_ff && (cmd_ff == CMD_FREE) && addr_ok && dec.free_hit
                     && !stack_full;
   assign do_note  = in_valid_ff && (cmd_ff == CMD_NOTE);

   // Counter updates for the selected class.
   always_comb begin
      fill_in    = cur_fill;
      live_in    = live_ff[cur_idx];
      alloc_in   = alloc_ff[cur_idx];
      release_in = release_ff[cur_idx];
      if (do_pop) begin
         fill_in = pop_fill;
      end
      if (do_alloc) begin
         live_in  = live_ff[cur_idx] + CNT_W'(1);
         alloc_in = alloc_ff[cur_idx] + CNT_W'(1);
      end
      if (do_push) begin
         fill_in    = cur_fill + FILL_W'(1);
         live_in    = live_ff[cur_idx] - CNT_W'(1);
         release_in = release_ff[cur_idx] + CNT_W'(1);
      end
   end

   assign large_in = do_large ? large_ff + CNT_W'(req_size_ff) : large_ff;

   // A fresh block widens the tracked range; its header sits just below it.
   assign hdr_addr = (addr_ff >= ADDR_W'(HEADER_BYTES)) ? addr_ff - ADDR_W'(HEADER_BYTES)
                                                        : '0;
   assign range_low_in  = (do_note && (hdr_addr < range_low_ff)) ? hdr_addr : range_low_ff;
   assign range_high_in = (do_note && (addr_ff > range_high_ff)) ? addr_ff : range_high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CLASSES; c++) begin
            fill_ff[c]    <= '0;
            live_ff[c]    <= '0;
            alloc_ff[c]   <= '0;
            release_ff[c] <= '0;
         end
         large_ff      <= '0;
         range_low_ff  <= '1;
         range_high_ff <= '0;
      end else begin
         if (do_alloc || do_push) begin
            fill_ff[cur_idx]    <= fill_in;
            live_ff[cur_idx]    <= live_in;
            alloc_ff[cur_idx]   <= alloc_in;
            release_ff[cur_idx] <= release_in;
         end
         large_ff      <= large_in;
         range_low_ff  <= range_low_in;
         range_high_ff <= range_high_in;
      end
   end

   // Each class owns LIST_DEPTH consecutive entries of the stack memory.
   assign mem_base    = MEM_AW'(cur_idx * LIST_DEPTH);
   assign mem_wr_addr = mem_base + MEM_AW'(cur_fill[IDX_W-1:0]);
   assign mem_rd_addr = mem_base + MEM_AW'(pop_fill[IDX_W-1:0]);

   scfl_ram #(
      .WIDTH (ADDR_W),
      .DEPTH (MEM_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (do_push),
      .wr_addr (mem_wr_addr),
      .wr_data (addr_ff),
      .rd_en   (do_pop),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Result status and the class whose counters are reported.
   always_comb begin
      status_in    = ST_STATS;
      report_class = 1'b0;
      case (cmd_ff)
         CMD_ALLOC: begin
            if (!dec.alloc_hit) begin
               status_in = ST_LARGE;
            end else begin
               status_in    = (cur_fill != '0) ? ST_REUSED : ST_FRESH;
               report_class = 1'b1;
            end
         end
         CMD_FREE: begin
            if (!addr_ok) begin
               status_in = ST_FREE_PASS;
            end else if (!dec.free_hit) begin
               status_in = ST_BAD_SIZE;
            end else begin
               status_in    = stack_full ? ST_LIST_FULL : ST_FREED;
               report_class = 1'b1;
            end
         end
         default: begin
            status_in    = ST_STATS;
            report_class = sel_ok;
         end
      endcase
   end

   assign rsp_valid_in   = in_valid_ff && (cmd_ff != CMD_NOTE);
   assign class_in       = report_class ? cur_class :
                           (cmd_ff == CMD_STATS) ? sel_ff : '0;
   assign rounded_in     = report_class ? class_bytes(cur_class) : '0;
   assign live_out_in    = report_class ? live_in : '0;
   assign free_out_in    = report_class ? CNT_W'(fill_in) : '0;
   assign alloc_out_in   = report_class ? alloc_in : '0;
   assign release_out_in = report_class ? release_in : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (rsp_valid_in) begin
         status_ff      <= status_in;
         class_ff       <= class_in;
         rounded_ff     <= rounded_in;
         reuse_ff       <= do_pop;
         live_out_ff    <= live_out_in;
         free_out_ff    <= free_out_in;
         alloc_out_ff   <= alloc_out_in;
         release_out_ff <= release_out_in;
         large_out_ff   <= large_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_class_index   = class_ff;
   assign rsp_rounded_size  = rounded_ff;
   // The popped address arrives from the memory's read register this cycle.
   assign rsp_block_address = reuse_ff ? mem_rd_data : '0;
   assign rsp_live_count    = live_out_ff;
   assign rsp_free_count    = free_out_ff;
   assign rsp_alloc_total   = alloc_out_ff;
   assign rsp_release_total = release_out_ff;
   assign rsp_large_bytes   = large_out_ff;

endmodule

// ----- hdl/scfl_checker.sv -----
// Port-level checker for the size-class allocator, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module scfl_port_props import scfl_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic [CMD_W-1:0]   req_command,
   input logic               rsp_valid,
   input logic [STAT_W-1:0]  rsp_status,
   input logic [CLASS_W-1:0] rsp_class_index,
   input logic [ROUND_W-1:0] rsp_rounded_size,
   input logic [ADDR_W-1:0]  rsp_block_address,
   input logic [CNT_W-1:0]   rsp_free_count
);

   logic cmd_taken;
   logic note_taken;
   logic classless_beat;
   logic class_fields_zero;

   assign cmd_taken         = start && !busy;
   assign note_taken        = cmd_taken && (req_command == CMD_NOTE);
   assign classless_beat    = rsp_valid && ((rsp_status == ST_LARGE) ||
                                            (rsp_status == ST_FREE_PASS) ||
                                            (rsp_status == ST_BAD_SIZE));
   assign class_fields_zero = (rsp_class_index == '0) && (rsp_rounded_size == '0) &&
                              (rsp_free_count == '0);

   // Every command but note_fresh returns a result beat.
   `SCFL_ASSERT_IMP(a_result_follows, clock, reset, cmd_taken && !note_taken, ##2 rsp_valid)

   // A note_fresh command returns nothing.
   `SCFL_ASSERT_IMP(a_note_silent, clock, reset, note_taken, ##2 !rsp_valid)

   // Only a reuse carries a block address.
   `SCFL_ASSERT_IMP(a_addr_only_reuse, clock, reset, rsp_valid && rsp_status != ST_REUSED, rsp_block_address == '0)

   // Passthrough and bad-size results name no class.
   `SCFL_ASSERT_IMP(a_no_class, clock, reset, classless_beat, class_fields_zero)

endmodule

bind size_class_free_list_allocator scfl_port_props u_scfl_port_props (.*);
